// ===== src/multi_stack_container_store_defines.svh =====
// Assertion macros for the multi stack container store.
// Used by the top level; no other dependencies.
`ifndef MULTI_STACK_CONTAINER_STORE_DEFINES_SVH
`define MULTI_STACK_CONTAINER_STORE_DEFINES_SVH

`ifndef SYNTHESIS
`define MSC_ASSERT_IMP(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("msc assertion failed");
`define MSC_ASSERT_NXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("msc assertion failed");
`else
`define MSC_ASSERT_IMP(label, clock, reset, ante, cons)
`define MSC_ASSERT_NXT(label, clock, reset, ante, cons)
`endif

`endif

// ===== src/msc_pkg.sv =====
// Shared sizes, codes and types of the multi stack container store.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package msc_pkg;

  localparam int MAX_BAYS    = 8;
  localparam int MAX_STACKS  = 8;
  localparam int MAX_HEIGHT  = 8;
  localparam int ID_WIDTH    = 16;
  localparam int NUM_STACKS  = MAX_BAYS * MAX_STACKS;
  localparam int STORE_DEPTH = NUM_STACKS * MAX_HEIGHT;

  localparam int IDX_W  = $clog2(NUM_STACKS);
  localparam int LVL_W  = $clog2(MAX_HEIGHT);
  localparam int HT_W   = $clog2(MAX_HEIGHT + 1);
  localparam int ADDR_W = IDX_W + LVL_W;
  localparam int SUM_W  = 8;
  localparam int REG_W  = 4;

  localparam logic REG_BAYS   = 1'b0;
  localparam logic REG_STACKS = 1'b1;

  typedef enum logic [2:0] {
    MODE_PUSH   = 3'd0,
    MODE_POP    = 3'd1,
    MODE_MOVE   = 3'd2,
    MODE_TOP    = 3'd3,
    MODE_HEIGHT = 3'd4,
    MODE_SEARCH = 3'd5,
    MODE_RDPOS  = 3'd6,
    MODE_UNUSED = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    ERR_OK    = 3'd0,
    ERR_EMPTY = 3'd1,
    ERR_FULL  = 3'd2,
    ERR_POS   = 3'd3,
    ERR_LOC   = 3'd4
  } err_t;

  function automatic logic [REG_W-1:0] clamp_reg(input logic [REG_W-1:0] v,
                                                 input logic [REG_W-1:0] hi);
    logic [REG_W-1:0] r;
    if (v == '0) r = REG_W'(1);
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/multi_stack_container_store.sv =====
// Top level of the multi stack container store: sequencer, height and id memories.
// Depends on msc_pkg and multi_stack_container_store_defines.svh.
//
// Usage:
//   s_axis carries one operation per beat (mode in tuser, addresses, id and
//   position in tdata). m_axis returns one result beat per operation.
//   Registers bays_in_use and stacks_in_use are written over the APB port; the
//   user must write them only while the block is idle, as the block itself
//   does not enforce it. Written values clamp to 1..8.
// Steps (one sequencer; the height and id memories have registered reads):
//   bad location, unused mode: straight to the result state
//   others read source, then destination height and decide; push, read height
//   and failed pop, top, move or read at position go to the result
//   pop, top, move, read at position, search: read the id memory; search reads
//   per level until a match or the top; a move between stacks writes the
//   destination, then the source height. A new beat is taken only in idle.
// Reset clears the registers to 8, all stack heights to zero (per-stack valid
// bits, no clearing pass) and the output valid flag. The id memory is not cleared.
// When the receiver stalls, the result beat holds in the output register and
// the block still takes one new beat, then waits before finishing it.
`timescale 1ns / 1ps
`default_nettype none
`include "multi_stack_container_store_defines.svh"

module multi_stack_container_store
  import msc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: src_bay[2:0], src_stack[5:3], dst_bay[8:6], dst_stack[11:9],
  //        container_id[27:12], position[30:28], zero[31]
  input  wire logic [31:0] s_axis_tdata,
  // tuser: mode[2:0]
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: id_out[15:0], height_out[19:16], found[20], error[23:21]
  output logic [23:0]      m_axis_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  typedef enum logic [2:0] {
    S_IDLE, S_RDS, S_RDD, S_DEC, S_SRD, S_SUSE, S_WRS, S_FIN
  } state_t;

  state_t state;

  logic [REG_W-1:0] bays_in_use, stacks_in_use;

  logic [2:0]          mode;
  logic [ID_WIDTH-1:0] id_in;
  logic [2:0]          pos;
  logic [IDX_W-1:0]    s_idx, d_idx;
  logic [HT_W-1:0]     h_s, h_d, h_fin;
  logic [LVL_W-1:0]    lvl;
  logic [ADDR_W-1:0]   saddr;
  logic [ID_WIDTH-1:0] id_r;
  logic                found_r;
  err_t                err_r;

  logic [ID_WIDTH-1:0] out_id;
  logic [HT_W-1:0]     out_height;
  logic                out_found;
  err_t                out_err;

  logic [HT_W-1:0]     hmem [NUM_STACKS];
  logic [NUM_STACKS-1:0] hvalid;
  logic [HT_W-1:0]     h_rd;
  logic                hv_rd;
  logic [HT_W-1:0]     h_cur;
  logic [IDX_W-1:0]    h_raddr;

  logic [ID_WIDTH-1:0] store [STORE_DEPTH];
  logic [ID_WIDTH-1:0] st_rd;

  logic                hw_en;
  logic [IDX_W-1:0]    hw_addr;
  logic [HT_W-1:0]     hw_data;
  logic                sw_en;
  logic [ADDR_W-1:0]   sw_addr;
  logic [ID_WIDTH-1:0] sw_data;

  logic [2:0]       in_sbay, in_sstk, in_dbay, in_dstk;
  logic [SUM_W-1:0] s_sum, d_sum;
  logic             loc_ok;
  logic             cfg_wr;
  logic             in_acc;
  logic [HT_W-1:0]  h_sm1;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[2] == REG_STACKS) ? 32'(stacks_in_use) : 32'(bays_in_use);

  assign s_axis_tready = (state == S_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;

  assign in_sbay = s_axis_tdata[2:0];
  assign in_sstk = s_axis_tdata[5:3];
  assign in_dbay = s_axis_tdata[8:6];
  assign in_dstk = s_axis_tdata[11:9];

  assign s_sum = SUM_W'(in_sbay) * SUM_W'(stacks_in_use) + SUM_W'(in_sstk);
  assign d_sum = SUM_W'(in_dbay) * SUM_W'(stacks_in_use) + SUM_W'(in_dstk);

  assign loc_ok = (REG_W'(in_sbay) < bays_in_use) && (REG_W'(in_sstk) < stacks_in_use) &&
                  ((s_axis_tuser != MODE_MOVE) ||
                   ((REG_W'(in_dbay) < bays_in_use) && (REG_W'(in_dstk) < stacks_in_use)));

  assign h_cur   = hv_rd ? h_rd : '0;
  assign h_raddr = (state == S_RDS) ? s_idx : d_idx;
  assign h_sm1   = h_s - HT_W'(1);

  assign m_axis_tdata = {out_err, out_found, out_height, out_id};

  always_comb begin
    hw_en   = 1'b0;
    hw_addr = s_idx;
    hw_data = '0;
    sw_en   = 1'b0;
    sw_addr = {s_idx, h_s[LVL_W-1:0]};
    sw_data = id_in;
    case (state)
      S_DEC: begin
        if (mode == MODE_PUSH && h_s < HT_W'(MAX_HEIGHT)) begin
          hw_en   = 1'b1;
          hw_data = h_s + HT_W'(1);
          sw_en   = 1'b1;
        end else if (mode == MODE_POP && h_s != '0) begin
          hw_en   = 1'b1;
          hw_data = h_sm1;
        end
      end
      S_SUSE: begin
        if (mode == MODE_MOVE && d_idx != s_idx) begin
          hw_en   = 1'b1;
          hw_addr = d_idx;
          hw_data = h_d + HT_W'(1);
          sw_en   = 1'b1;
          sw_addr = {d_idx, h_d[LVL_W-1:0]};
          sw_data = st_rd;
        end
      end
      S_WRS: begin
        hw_en   = 1'b1;
        hw_data = h_sm1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (hw_en) hmem[hw_addr] <= hw_data;
    h_rd <= hmem[h_raddr];
    hv_rd <= hvalid[h_raddr];
    if (sw_en) store[sw_addr] <= sw_data;
    st_rd <= store[saddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hvalid <= '0;
    end else if (hw_en) begin
      hvalid[hw_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bays_in_use   <= REG_W'(MAX_BAYS);
      stacks_in_use <= REG_W'(MAX_STACKS);
    end else if (cfg_wr) begin
      if (paddr[2] == REG_BAYS) bays_in_use <= clamp_reg(pwdata[REG_W-1:0], REG_W'(MAX_BAYS));
      else stacks_in_use <= clamp_reg(pwdata[REG_W-1:0], REG_W'(MAX_STACKS));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && state != S_FIN) m_axis_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            mode    <= s_axis_tuser;
            id_in   <= s_axis_tdata[27:12];
            pos     <= s_axis_tdata[30:28];
            s_idx   <= s_sum[IDX_W-1:0];
            d_idx   <= d_sum[IDX_W-1:0];
            id_r    <= '0;
            found_r <= 1'b0;
            err_r   <= ERR_OK;
            h_fin   <= '0;
            if (s_axis_tuser == MODE_UNUSED) begin
              state <= S_FIN;
            end else if (!loc_ok) begin
              err_r <= ERR_LOC;
              state <= S_FIN;
            end else begin
              state <= S_RDS;
            end
          end
        end
        S_RDS: state <= S_RDD;
        S_RDD: begin
          h_s   <= h_cur;
          state <= S_DEC;
        end
        S_DEC: begin
          h_d   <= h_cur;
          h_fin <= h_s;
          state <= S_FIN;
          case (mode)
            MODE_PUSH: begin
              if (h_s >= HT_W'(MAX_HEIGHT)) err_r <= ERR_FULL;
              else h_fin <= h_s + HT_W'(1);
            end
            MODE_POP: begin
              if (h_s == '0) begin
                err_r <= ERR_EMPTY;
              end else begin
                h_fin <= h_sm1;
                saddr <= {s_idx, h_sm1[LVL_W-1:0]};
                state <= S_SRD;
              end
            end
            MODE_MOVE: begin
              if (h_s == '0) begin
                err_r <= ERR_EMPTY;
              end else if (d_idx != s_idx && h_cur >= HT_W'(MAX_HEIGHT)) begin
                err_r <= ERR_FULL;
              end else begin
                saddr <= {s_idx, h_sm1[LVL_W-1:0]};
                state <= S_SRD;
              end
            end
            MODE_TOP: begin
              if (h_s == '0) begin
                err_r <= ERR_EMPTY;
              end else begin
                saddr <= {s_idx, h_sm1[LVL_W-1:0]};
                state <= S_SRD;
              end
            end
            MODE_SEARCH: begin
              if (h_s != '0) begin
                lvl   <= '0;
                saddr <= {s_idx, {LVL_W{1'b0}}};
                state <= S_SRD;
              end
            end
            MODE_RDPOS: begin
              if (HT_W'(pos) >= h_s) begin
                err_r <= ERR_POS;
              end else begin
                saddr <= {s_idx, pos[LVL_W-1:0]};
                state <= S_SRD;
              end
            end
            default: begin
            end
          endcase
        end
        S_SRD: state <= S_SUSE;
        S_SUSE: begin
          state <= S_FIN;
          if (mode == MODE_SEARCH) begin
            if (st_rd == id_in) begin
              found_r <= 1'b1;
            end else if (HT_W'(lvl) != h_sm1) begin
              lvl   <= lvl + LVL_W'(1);
              saddr <= {s_idx, lvl + LVL_W'(1)};
              state <= S_SRD;
            end
          end else begin
            id_r <= st_rd;
            if (mode == MODE_MOVE && d_idx != s_idx) begin
              h_fin <= h_sm1;
              state <= S_WRS;
            end
          end
        end
        S_WRS: state <= S_FIN;
        S_FIN: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            out_id        <= id_r;
            out_height    <= h_fin;
            out_found     <= found_r;
            out_err       <= err_r;
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `MSC_ASSERT_NXT(a_busy_after_accept, clk, rst, in_acc, !s_axis_tready)
  `MSC_ASSERT_IMP(a_loc_err_zero, clk, rst, m_axis_tvalid && out_err == ERR_LOC,
                  out_height == '0 && out_id == '0 && !out_found)
  `MSC_ASSERT_IMP(a_found_clean, clk, rst, m_axis_tvalid && out_found,
                  out_err == ERR_OK && out_id == '0)
  `MSC_ASSERT_IMP(a_height_bound, clk, rst, hw_en, hw_data <= HT_W'(MAX_HEIGHT))

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for multi_stack_container_store: stream stimulus, APB setup.
// Predicts every result beat in a scoreboard class; needs msc_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
  import msc_pkg::*;

  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    logic [2:0]  mode;
    logic [2:0]  src_bay;
    logic [2:0]  src_stack;
    logic [2:0]  dst_bay;
    logic [2:0]  dst_stack;
    logic [15:0] container_id;
    logic [2:0]  position;
  } yard_op_t;

  typedef struct packed {
    logic [15:0] id;
    logic [3:0]  height;
    logic        found;
    err_t        error;
  } yard_result_t;

  class stack_yard;
    logic [ID_WIDTH-1:0] slots [STORE_DEPTH];
    int levels [NUM_STACKS];
    int bays_in_use;
    int stacks_in_use;
    yard_result_t awaited [$];
    int mismatches;

    function new();
      foreach (slots[i]) slots[i] = '0;
      foreach (levels[i]) levels[i] = 0;
      bays_in_use = MAX_BAYS;
      stacks_in_use = MAX_STACKS;
      mismatches = 0;
    endfunction

    function void set_reg(logic sel, logic [31:0] word);
      int v;
      int hi;
      v = int'(word[3:0]);
      hi = (sel == REG_BAYS) ? MAX_BAYS : MAX_STACKS;
      if (v == 0) v = 1;
      else if (v > hi) v = hi;
      if (sel == REG_BAYS) bays_in_use = v;
      else stacks_in_use = v;
    endfunction

    function bit locate(logic [2:0] bay, logic [2:0] stk, output int idx);
      idx = 0;
      if (bay >= bays_in_use || stk >= stacks_in_use) return 1'b0;
      idx = bay * stacks_in_use + stk;
      return idx < NUM_STACKS;
    endfunction

    function yard_result_t predict(yard_op_t op);
      yard_result_t r;
      int s;
      int d;
      int h;
      logic [ID_WIDTH-1:0] top;
      r.id = '0;
      r.height = '0;
      r.found = 1'b0;
      r.error = ERR_OK;
      if (op.mode == MODE_UNUSED) return r;
      if (!locate(op.src_bay, op.src_stack, s) ||
          (op.mode == MODE_MOVE && !locate(op.dst_bay, op.dst_stack, d))) begin
        r.error = ERR_LOC;
        return r;
      end
      h = levels[s];
      case (op.mode)
        MODE_PUSH: begin
          if (h >= MAX_HEIGHT) r.error = ERR_FULL;
          else begin
            slots[s * MAX_HEIGHT + h] = op.container_id;
            levels[s] = h + 1;
          end
        end
        MODE_POP: begin
          if (h == 0) r.error = ERR_EMPTY;
          else begin
            r.id = slots[s * MAX_HEIGHT + h - 1];
            levels[s] = h - 1;
          end
        end
        MODE_MOVE: begin
          if (h == 0) r.error = ERR_EMPTY;
          else begin
            top = slots[s * MAX_HEIGHT + h - 1];
            if (d == s) r.id = top;
            else if (levels[d] >= MAX_HEIGHT) r.error = ERR_FULL;
            else begin
              slots[d * MAX_HEIGHT + levels[d]] = top;
              levels[d] = levels[d] + 1;
              levels[s] = h - 1;
              r.id = top;
            end
          end
        end
        MODE_TOP: begin
          if (h == 0) r.error = ERR_EMPTY;
          else r.id = slots[s * MAX_HEIGHT + h - 1];
        end
        MODE_SEARCH: begin
          for (int i = 0; i < h; i++)
            if (slots[s * MAX_HEIGHT + i] == op.container_id) r.found = 1'b1;
        end
        MODE_RDPOS: begin
          if (op.position >= h) r.error = ERR_POS;
          else r.id = slots[s * MAX_HEIGHT + op.position];
        end
        default: ;
      endcase
      r.height = 4'(levels[s]);
      return r;
    endfunction

    function void note_op(yard_op_t op);
      awaited = {awaited, predict(op)};
    endfunction

    task report(string what);
      mismatches++;
      $display("%0t ns: %s", $realtime, what);
    endtask

    task check_beat(logic [23:0] beat);
      yard_result_t want;
      if (awaited.size() == 0) begin
        report($sformatf("result beat %h with nothing pending", beat));
        return;
      end
      want = awaited.pop_front();
      if (beat[15:0] !== want.id)
        report($sformatf("id_out %h, want %h", beat[15:0], want.id));
      if (beat[19:16] !== want.height)
        report($sformatf("height_out %0d, want %0d", beat[19:16], want.height));
      if (beat[20] !== want.found)
        report($sformatf("found %b, want %b", beat[20], want.found));
      if (beat[23:21] !== want.error)
        report($sformatf("error %0d, want %0d", beat[23:21], want.error));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  bit calm = 1'b0;
  int cycles = 0;
  logic [15:0] id_pool [8] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h0001,
                               16'h5A5A, 16'h1234, 16'h7FFF, 16'hC3C3};
  stack_yard yard = new();

  multi_stack_container_store DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) yard.check_beat(m_axis_tdata);
    m_axis_tready <= calm || ($urandom_range(99) >= 7);
  end

  function automatic yard_op_t mk(logic [2:0] mode, int sb, int ss, int db, int ds,
                                  logic [15:0] id, int pos);
    yard_op_t op;
    op.mode = mode;
    op.src_bay = 3'(sb);
    op.src_stack = 3'(ss);
    op.dst_bay = 3'(db);
    op.dst_stack = 3'(ds);
    op.container_id = id;
    op.position = 3'(pos);
    return op;
  endfunction

  function automatic logic [5:0] pick_loc();
    int roll;
    logic [2:0] b;
    logic [2:0] s;
    roll = $urandom_range(99);
    if (roll < 10) begin
      b = 3'($urandom());
      s = 3'($urandom());
    end else if (roll < 65) begin
      b = 3'($urandom_range((yard.bays_in_use > 2 ? 2 : yard.bays_in_use) - 1));
      s = 3'($urandom_range((yard.stacks_in_use > 2 ? 2 : yard.stacks_in_use) - 1));
    end else begin
      b = 3'($urandom_range(yard.bays_in_use - 1));
      s = 3'($urandom_range(yard.stacks_in_use - 1));
    end
    return {b, s};
  endfunction

  function automatic yard_op_t random_op();
    yard_op_t op;
    int roll;
    roll = $urandom_range(99);
    if (roll < 30) op.mode = MODE_PUSH;
    else if (roll < 45) op.mode = MODE_POP;
    else if (roll < 60) op.mode = MODE_MOVE;
    else if (roll < 68) op.mode = MODE_TOP;
    else if (roll < 75) op.mode = MODE_HEIGHT;
    else if (roll < 87) op.mode = MODE_SEARCH;
    else if (roll < 97) op.mode = MODE_RDPOS;
    else op.mode = MODE_UNUSED;
    {op.src_bay, op.src_stack} = pick_loc();
    {op.dst_bay, op.dst_stack} = pick_loc();
    op.container_id = ($urandom_range(99) < 60) ? id_pool[$urandom_range(7)]
                                                : 16'($urandom());
    op.position = 3'($urandom());
    return op;
  endfunction

  task automatic send_op(input yard_op_t op);
    while (!calm && $urandom_range(99) < 7) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op.mode;
    s_axis_tdata <= {1'b0, op.position, op.container_id, op.dst_stack, op.dst_bay,
                     op.src_stack, op.src_bay};
    do @(posedge clk); while (!s_axis_tready);
    yard.note_op(op);
  endtask

  // hold off until every pending result is out, then let the block settle
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    while (yard.awaited.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic write_reg(input logic sel, input logic [3:0] value);
    logic [31:0] word;
    word = {28'($urandom()), value};
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    yard.set_reg(sel, word);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int bays_plan [8] = '{8, 1, 2, 15, 8, 1, 0, 4};
    int stacks_plan [8] = '{8, 1, 3, 9, 1, 8, 0, 4};
    logic [15:0] fill [8] = '{16'hFFFF, 16'h0000, 16'h8000, 16'h0001,
                              16'hAAAA, 16'h5555, 16'h1234, 16'hFFFE};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_op(mk(MODE_HEIGHT, 0, 0, 0, 0, 16'h0000, 0));
    send_op(mk(MODE_POP, 0, 0, 0, 0, 16'h0000, 0));
    send_op(mk(MODE_TOP, 0, 0, 0, 0, 16'h0000, 0));
    send_op(mk(MODE_MOVE, 0, 0, 0, 1, 16'h0000, 0));
    send_op(mk(MODE_RDPOS, 0, 0, 0, 0, 16'h0000, 0));
    send_op(mk(MODE_SEARCH, 0, 0, 0, 0, 16'h0000, 0));
    foreach (fill[i]) send_op(mk(MODE_PUSH, 7, 7, 0, 0, fill[i], 0));
    send_op(mk(MODE_PUSH, 7, 7, 0, 0, 16'h4321, 0));
    send_op(mk(MODE_RDPOS, 7, 7, 0, 0, 16'h0000, 7));
    send_op(mk(MODE_SEARCH, 7, 7, 0, 0, 16'hFFFF, 0));
    send_op(mk(MODE_SEARCH, 7, 7, 0, 0, 16'hBEEF, 0));
    send_op(mk(MODE_PUSH, 0, 0, 0, 0, 16'h0042, 0));
    send_op(mk(MODE_MOVE, 0, 0, 7, 7, 16'h0000, 0));
    send_op(mk(MODE_MOVE, 7, 7, 7, 7, 16'h0000, 0));
    send_op(mk(MODE_MOVE, 7, 7, 0, 0, 16'h0000, 0));
    send_op(mk(MODE_POP, 0, 0, 0, 0, 16'h0000, 0));
    send_op(mk(MODE_TOP, 0, 0, 0, 0, 16'h0000, 0));
    send_op(mk(MODE_UNUSED, 7, 7, 7, 7, 16'hFFFF, 7));

    quiesce();
    write_reg(REG_BAYS, 4'd0);
    write_reg(REG_STACKS, 4'd15);
    send_op(mk(MODE_PUSH, 1, 0, 0, 0, 16'h0007, 0));
    send_op(mk(MODE_MOVE, 0, 0, 3, 2, 16'h0000, 0));
    send_op(mk(MODE_RDPOS, 0, 7, 0, 0, 16'h0000, 3));

    bays_plan[6] = $urandom_range(15);
    stacks_plan[6] = $urandom_range(15);
    for (int p = 0; p < 8; p++) begin
      quiesce();
      write_reg(REG_BAYS, 4'(bays_plan[p]));
      write_reg(REG_STACKS, 4'(stacks_plan[p]));
      calm = (p == 3);
      for (int n = 0; n < 150; n++) send_op(random_op());
    end
    calm = 1'b0;

    s_axis_tvalid <= 1'b0;
    while (yard.awaited.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (yard.mismatches == 0 && yard.awaited.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/msc_pkg.sv
src/multi_stack_container_store.sv
test/tb.sv
